[design/xfc_pkg.sv]
package xfc_pkg;

    localparam int DataW   = 8;
    localparam int PosW    = 9;
    localparam int StatusW = 2;
    localparam int TdataW  = 16;

    localparam logic [DataW-1:0] HEAD_FIRST  = 8'hAA;
    localparam logic [DataW-1:0] HEAD_SECOND = 8'h55;
    localparam logic [DataW-1:0] TAIL_FIRST  = 8'h55;
    localparam logic [DataW-1:0] TAIL_SECOND = 8'hAA;

    typedef enum logic [StatusW-1:0] {
        ST_VALID    = 2'd0,
        ST_HEADER   = 2'd1,
        ST_TAIL     = 2'd2,
        ST_CHECKSUM = 2'd3
    } xfc_status_t;

    typedef struct packed {
        logic [DataW-1:0] data_byte;
        logic             frame_start;
    } xfc_item_t;

    typedef struct packed {
        xfc_status_t      status;
        logic [DataW-1:0] body_length;
    } xfc_result_t;

    // handshake between the input register and the check stage
    typedef struct packed {
        logic valid;
        logic advance;
    } xfc_link_t;

endpackage

[design/xfc_in_reg.sv]
module xfc_in_reg
    import xfc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  xfc_item_t s_item,
    input  logic      advance,
    output xfc_link_t link,
    output xfc_item_t item
);

    logic      valid_reg;
    logic      valid_next;
    xfc_item_t item_reg;

    assign s_tready   = !valid_reg || advance;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

    assign link.valid   = valid_reg;
    assign link.advance = advance;
    assign item         = item_reg;

endmodule

[design/xfc_check.sv]
module xfc_check
    import xfc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  xfc_link_t   link,
    input  xfc_item_t   item,
    output logic        res_valid,
    output xfc_result_t res
);

    logic [PosW-1:0]  pos_reg,    pos_next;
    logic [DataW-1:0] len_reg,    len_next;
    logic [DataW-1:0] xor_reg,    xor_next;
    logic             bad_reg,    bad_next;
    logic             active_reg, active_next;

    logic [PosW-1:0]  eff_pos;
    logic [DataW-1:0] eff_len;
    logic [DataW-1:0] eff_xor;
    logic             eff_bad;
    logic             eff_active;
    logic [PosW-1:0]  len_ext;
    logic             step;
    logic             emit;
    xfc_result_t      emit_res;

    assign step = link.valid && link.advance;

    always_comb begin
        eff_pos    = item.frame_start ? '0 : pos_reg;
        eff_len    = item.frame_start ? '0 : len_reg;
        eff_xor    = item.frame_start ? '0 : xor_reg;
        eff_bad    = item.frame_start ? 1'b0 : bad_reg;
        eff_active = item.frame_start || active_reg;
        len_ext    = {1'b0, eff_len};

        pos_next    = eff_pos;
        len_next    = eff_len;
        xor_next    = eff_xor;
        bad_next    = eff_bad;
        active_next = eff_active;
        emit        = 1'b0;
        emit_res.status      = ST_VALID;
        emit_res.body_length = eff_len;

        if (eff_active) begin
            pos_next = eff_pos + 1'b1;
            priority if (eff_pos == 9'd0) begin
                if (item.data_byte != HEAD_FIRST) begin
                    emit = 1'b1;
                    emit_res.status      = ST_HEADER;
                    emit_res.body_length = '0;
                end
            end else if (eff_pos == 9'd1) begin
                if (item.data_byte != HEAD_SECOND) begin
                    emit = 1'b1;
                    emit_res.status      = ST_HEADER;
                    emit_res.body_length = '0;
                end
            end else if (eff_pos == 9'd2) begin
                len_next = item.data_byte;
                xor_next = item.data_byte;
            end else if (eff_pos < len_ext + 9'd3) begin
                xor_next = eff_xor ^ item.data_byte;
            end else if (eff_pos == len_ext + 9'd3) begin
                bad_next = (eff_xor != item.data_byte);
            end else if (eff_pos == len_ext + 9'd4) begin
                if (item.data_byte != TAIL_FIRST) begin
                    emit = 1'b1;
                    emit_res.status = ST_TAIL;
                end
            end else begin
                // last tail byte
                emit = 1'b1;
                priority if (item.data_byte != TAIL_SECOND) begin
                    emit_res.status = ST_TAIL;
                end else if (eff_bad) begin
                    emit_res.status = ST_CHECKSUM;
                end else begin
                    emit_res.status = ST_VALID;
                end
            end
            if (emit) begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            len_reg    <= '0;
            xor_reg    <= '0;
            bad_reg    <= 1'b0;
            active_reg <= 1'b0;
        end else if (step) begin
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            xor_reg    <= xor_next;
            bad_reg    <= bad_next;
            active_reg <= active_next;
        end
    end

    assign res_valid = step && emit;
    assign res       = emit_res;

`ifndef NO_ASSERTIONS
    a_verdict_ends_frame: assert property (
        @(posedge aclk) disable iff (!aresetn)
        res_valid |=> !active_reg
    ) else $error("frame still active after its verdict");

    a_pos_in_frame: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (active_reg && pos_reg > 9'd2) |-> (pos_reg <= {1'b0, len_reg} + 9'd5)
    ) else $error("byte position ran past the tail");

    a_header_len_zero: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (res_valid && res.status == ST_HEADER) |-> (res.body_length == '0)
    ) else $error("header error with nonzero length");

    a_idle_silent: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (link.valid && !item.frame_start && !active_reg) |-> !res_valid
    ) else $error("verdict from an idle checker");
`endif

endmodule

[design/xfc_out_reg.sv]
module xfc_out_reg
    import xfc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                res_valid,
    input  xfc_result_t         res,
    output logic                advance,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [TdataW-1:0]   m_tdata
);

    logic        valid_reg;
    logic        valid_next;
    xfc_result_t res_reg;

    assign advance    = !valid_reg || m_tready;
    assign valid_next = advance ? res_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(TdataW - StatusW - DataW){1'b0}}, res_reg.body_length, res_reg.status};

endmodule

[design/xor_frame_checker_core.sv]
// Byte-serial frame checker. A frame is AA 55, a length byte L, L body
// bytes, a check byte equal to the XOR of L and the body, then 55 AA. Each
// byte is presented with s_tuser high on the first byte of a frame, which
// restarts the checker and drops any frame in progress. At most one
// verdict transaction is issued per frame: a header error at the bad
// header byte, a tail error at the first wrong tail byte, otherwise a
// checksum error or valid status on the last tail byte. Bytes outside a
// frame are ignored. One byte is taken every clock while the result side
// is not stalled; each byte passes through the input register, the
// combinational check logic and the result register to its verdict.
module xor_frame_checker_core
    import xfc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DataW-1:0]  s_tdata,   // [7:0] data_byte
    input  logic              s_tuser,   // [0] frame_start
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [TdataW-1:0] m_tdata    // [1:0] status, [9:2] body_length
);

    xfc_item_t   s_item;
    xfc_item_t   item;
    xfc_link_t   link;
    logic        advance;
    logic        res_valid;
    xfc_result_t res;

    assign s_item.data_byte   = s_tdata;
    assign s_item.frame_start = s_tuser;

    xfc_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_item   (s_item),
        .advance  (advance),
        .link     (link),
        .item     (item)
    );

    xfc_check u_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .link      (link),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    xfc_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .advance   (advance),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

[verif/testbench.sv]
module testbench
    import xfc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BYTES = 525;
    localparam int N_DIRECTED   = 25;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_FIXED
    } chk_t;

    typedef struct packed {
        logic [DataW-1:0] b;
        logic             first;
        chk_t             chk;
        xfc_status_t      st;
        logic [DataW-1:0] len;
    } dir_row_t;

    // header errors, ignored bytes, good frame, bad tail, restart mid-frame, bad checksum
    dir_row_t dir_rows [N_DIRECTED] = '{
        '{8'h00,       1'b0, CHK_NONE,  ST_VALID,    8'd0},
        '{8'h00,       1'b1, CHK_FIXED, ST_HEADER,   8'd0},
        '{8'h55,       1'b0, CHK_NONE,  ST_VALID,    8'd0},
        '{HEAD_FIRST,  1'b1, CHK_MODEL, ST_VALID,    8'd0},
        '{8'h54,       1'b0, CHK_FIXED, ST_HEADER,   8'd0},
        '{HEAD_FIRST,  1'b1, CHK_MODEL, ST_VALID,    8'd0},
        '{HEAD_SECOND, 1'b0, CHK_MODEL, ST_VALID,    8'd0},
        '{8'h00,       1'b0, CHK_MODEL, ST_VALID,    8'd0},
        '{8'h00,       1'b0, CHK_MODEL, ST_VALID,    8'd0},
        '{TAIL_FIRST,  1'b0, CHK_MODEL, ST_VALID,    8'd0},
        '{TAIL_SECOND, 1'b0, CHK_FIXED, ST_VALID,    8'd0},
        '{HEAD_FIRST,  1'b1, CHK_MODEL, ST_VALID,    8'd0},
        '{HEAD_SECOND, 1'b0, CHK_MODEL, ST_VALID,    8'd0},
        '{8'h01,       1'b0, CHK_MODEL, ST_VALID,    8'd0},
        '{8'hFF,       1'b0, CHK_MODEL, ST_VALID,    8'd0},
        '{8'h00,       1'b0, CHK_MODEL, ST_VALID,    8'd0},
        '{8'h54,       1'b0, CHK_FIXED, ST_TAIL,     8'd1},
        '{HEAD_FIRST,  1'b1, CHK_MODEL, ST_VALID,    8'd0},
        '{HEAD_SECOND, 1'b0, CHK_MODEL, ST_VALID,    8'd0},
        '{HEAD_FIRST,  1'b1, CHK_MODEL, ST_VALID,    8'd0},
        '{HEAD_SECOND, 1'b0, CHK_MODEL, ST_VALID,    8'd0},
        '{8'h00,       1'b0, CHK_MODEL, ST_VALID,    8'd0},
        '{8'hFF,       1'b0, CHK_MODEL, ST_VALID,    8'd0},
        '{TAIL_FIRST,  1'b0, CHK_MODEL, ST_VALID,    8'd0},
        '{TAIL_SECOND, 1'b0, CHK_FIXED, ST_CHECKSUM, 8'd0}
    };

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DataW-1:0]  s_tdata  = '0;
    logic              s_tuser  = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [TdataW-1:0] m_tdata;

    // expectation kind travelling with each input transaction
    chk_t              row_chk    = CHK_MODEL;
    xfc_status_t       row_status = ST_VALID;
    logic [DataW-1:0]  row_len    = '0;

    // predictor state
    logic [PosW-1:0]   frame_pos      = '0;
    logic [DataW-1:0]  frame_len      = '0;
    logic [DataW-1:0]  frame_xor      = '0;
    logic              frame_csum_bad = 1'b0;
    logic              frame_open     = 1'b0;

    xfc_result_t       pending_verdicts [$];
    int                mismatch_cnt = 0;
    int                cycle_cnt    = 0;
    int                hold_left    = 0;
    bit                ready_steady = 1'b0;
    bit                got_verdict;
    xfc_result_t       model_verdict;
    xfc_result_t       want_verdict;

    xor_frame_checker_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int pick_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 40);
    endfunction

    task automatic judge_byte(input logic [DataW-1:0] b, input logic first,
                              output bit fired, output xfc_result_t v);
        logic [PosW-1:0] at;
        logic [PosW-1:0] body_end;
        fired = 1'b0;
        v     = '0;
        if (first) begin
            frame_pos      = '0;
            frame_len      = '0;
            frame_xor      = '0;
            frame_csum_bad = 1'b0;
            frame_open     = 1'b1;
        end
        if (!frame_open) begin
            return;
        end
        at        = frame_pos;
        frame_pos = frame_pos + 1'b1;
        body_end  = {1'b0, frame_len} + 9'd3;
        if (at == 0) begin
            if (b != HEAD_FIRST) begin
                fired = 1'b1;
                v.status = ST_HEADER;
            end
        end else if (at == 1) begin
            if (b != HEAD_SECOND) begin
                fired = 1'b1;
                v.status = ST_HEADER;
            end
        end else if (at == 2) begin
            frame_len = b;
            frame_xor = b;
        end else if (at < body_end) begin
            frame_xor = frame_xor ^ b;
        end else if (at == body_end) begin
            frame_csum_bad = (frame_xor != b);
        end else if (at == body_end + 1'b1) begin
            if (b != TAIL_FIRST) begin
                fired = 1'b1;
                v.status = ST_TAIL;
                v.body_length = frame_len;
            end
        end else begin
            fired = 1'b1;
            v.body_length = frame_len;
            if (b != TAIL_SECOND) begin
                v.status = ST_TAIL;
            end else if (frame_csum_bad) begin
                v.status = ST_CHECKSUM;
            end else begin
                v.status = ST_VALID;
            end
        end
        if (fired) begin
            frame_open = 1'b0;
        end
    endtask

    task automatic note_failure(input string what, input xfc_result_t want,
                                input logic [TdataW-1:0] got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
            $display("%0t %s: expected status %0d length %0d, got status %0d length %0d",
                     $time, what, want.status, want.body_length, got[1:0], got[9:2]);
        end
    endtask

    // result side checks, then predict on accepted input
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_verdicts.size() == 0) begin
                    note_failure("unexpected verdict", '0, m_tdata);
                end else begin
                    want_verdict = pending_verdicts.pop_front();
                    if (m_tdata[1:0] != want_verdict.status) begin
                        note_failure("status mismatch", want_verdict, m_tdata);
                    end else if (m_tdata[9:2] != want_verdict.body_length) begin
                        note_failure("length mismatch", want_verdict, m_tdata);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                judge_byte(s_tdata, s_tuser, got_verdict, model_verdict);
                case (row_chk)
                    CHK_MODEL: begin
                        if (got_verdict) begin
                            pending_verdicts.push_back(model_verdict);
                        end
                    end
                    CHK_FIXED: begin
                        want_verdict.status      = row_status;
                        want_verdict.body_length = row_len;
                        pending_verdicts.push_back(want_verdict);
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // result side stalls
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= 1'b1;
            if (!ready_steady && $urandom_range(0, 3) == 0) begin
                hold_left <= pick_gap(1'b0);
            end
        end
        if ($urandom_range(0, 199) == 0) begin
            ready_steady <= !ready_steady;
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_byte(input logic [DataW-1:0] b, input logic first,
                             input chk_t chk, input xfc_status_t st,
                             input logic [DataW-1:0] len, input int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= b;
        s_tuser    <= first;
        row_chk    <= chk;
        row_status <= st;
        row_len    <= len;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_noise(input int n, input bit steady);
        repeat (n) begin
            send_byte(8'($urandom), 1'b0, CHK_MODEL, ST_VALID, '0, pick_gap(steady));
        end
    endtask

    task automatic random_frame(input bit force_long, output int n_sent);
        logic [DataW-1:0] fr [$];
        logic [DataW-1:0] body_len;
        logic [DataW-1:0] csum;
        logic [DataW-1:0] b;
        int               flaw;
        int               n_keep;
        bit               steady;
        flaw   = $urandom_range(0, 19);
        steady = ($urandom_range(0, 3) == 0);
        if (force_long) begin
            body_len = 8'hFF;
        end else if ($urandom_range(0, 39) == 0) begin
            body_len = 8'($urandom_range(200, 255));
        end else begin
            body_len = 8'($urandom_range(0, 8));
        end
        fr.push_back(HEAD_FIRST);
        fr.push_back(HEAD_SECOND);
        fr.push_back(body_len);
        csum = body_len;
        repeat (body_len) begin
            b = 8'($urandom);
            fr.push_back(b);
            csum = csum ^ b;
        end
        fr.push_back(csum);
        fr.push_back(TAIL_FIRST);
        fr.push_back(TAIL_SECOND);
        n_keep = fr.size();
        case (flaw)
            0: fr[0] = 8'($urandom);
            1: fr[1] = 8'($urandom);
            2: fr[body_len + 3] = fr[body_len + 3] ^ 8'($urandom_range(1, 255));
            3: fr[body_len + 4] = 8'($urandom);
            4: fr[body_len + 5] = 8'($urandom);
            5: n_keep = $urandom_range(1, fr.size() - 1);
            6: fr[2] = 8'($urandom);
            default: begin
            end
        endcase
        if ($urandom_range(0, 9) == 0) begin
            send_noise($urandom_range(1, 3), steady);
        end
        for (int i = 0; i < n_keep; i++) begin
            send_byte(fr[i], i == 0, CHK_MODEL, ST_VALID, '0, pick_gap(steady));
        end
        if (flaw == 7) begin
            send_noise($urandom_range(1, 4), steady);
        end
        n_sent = n_keep;
    endtask

    initial begin
        int frame_bytes;
        int n_frames;
        int n_sent;
        frame_bytes = 0;
        n_frames    = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_byte(dir_rows[i].b, dir_rows[i].first, dir_rows[i].chk, dir_rows[i].st,
                      dir_rows[i].len, pick_gap(1'b0));
        end
        while (frame_bytes < RANDOM_BYTES) begin
            random_frame(n_frames == 12, n_sent);
            frame_bytes += n_sent;
            n_frames++;
        end
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatch_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[sim.f]
design/xfc_pkg.sv
design/xfc_in_reg.sv
design/xfc_check.sv
design/xfc_out_reg.sv
design/xor_frame_checker_core.sv
verif/testbench.sv
